// File: hdl/mvtt_pkg.sv
// Package for the mixer valve temperature trim unit.
// Holds the beat types, the configuration record, register indexes and fixed constants.
// Has no dependencies; every other file in hdl refers to it by scoped names.
package mvtt_pkg;

	// One input beat: two temperatures in sixteenths of a degree Celsius.
	typedef struct packed {
		logic signed [11:0] source_temp;
		logic signed [11:0] return_temp;
	} sample_t;

	// One result beat.
	typedef struct packed {
		logic              step_ran;
		logic [7:0]        valve_position;
		logic              position_changed;
		logic signed [7:0] source_error;
		logic signed [7:0] return_error;
		logic              source_near;
		logic              source_at;
		logic              return_near;
		logic              return_at;
	} result_t;

	// Configuration registers as held inside the block.
	typedef struct packed {
		logic [7:0]  setpoint;
		logic [3:0]  near_band;
		logic [3:0]  undershoot_band;
		logic [3:0]  overshoot_band;
		logic [3:0]  trim_gain;
		logic [15:0] postscale_limit;
	} cfg_t;

	// Register indexes on the write port.
	typedef enum logic [2:0] {
		REG_SETPOINT        = 3'd0,
		REG_NEAR_BAND       = 3'd1,
		REG_UNDERSHOOT_BAND = 3'd2,
		REG_OVERSHOOT_BAND  = 3'd3,
		REG_TRIM_GAIN       = 3'd4,
		REG_POSTSCALE_LIMIT = 3'd5
	} reg_index_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Values after reset.
	localparam logic [7:0]  SETPOINT_RST        = 8'd25;
	localparam logic [3:0]  NEAR_BAND_RST       = 4'd5;
	localparam logic [3:0]  UNDERSHOOT_BAND_RST = 4'd3;
	localparam logic [3:0]  OVERSHOOT_BAND_RST  = 4'd2;
	localparam logic [3:0]  TRIM_GAIN_RST       = 4'd6;
	localparam logic [15:0] POSTSCALE_LIMIT_RST = 16'd200;

	// Feedforward line: position = FF_BASE_POS - 8 * (setpoint - FF_BASE_TEMP).
	localparam logic signed [12:0] FF_BASE_POS  = 13'sd200;
	localparam logic signed [9:0]  FF_BASE_TEMP = 10'sd25;
	localparam int                 FF_SLOPE_SHIFT = 3;

	localparam logic [7:0] POS_MAX    = 8'd255;
	localparam logic [7:0] POS_MIN    = 8'd0;
	localparam logic [7:0] POS_TOP_OK = 8'd254;

	// Sixteenths per degree, as a shift.
	localparam int FRAC_SHIFT = 4;

endpackage

// File: hdl/mixer_valve_temperature_trim_unit.sv
// Top level of the mixer valve temperature trim unit.
// Holds the input stage, result register, postscaler, valve state and configuration registers;
// depends on mvtt_pkg, mvtt_temp_check and mvtt_position.
//
//   Channel   Signals                                   Moves
//   --------  ----------------------------------------  ------------------------------------
//   sample    sample_valid, sample_ready, sample        one sensor tick per beat (sample_t)
//   result    result_valid, result_ready, result        one result per tick (result_t)
//   config    cfg_write, cfg_index, cfg_data            register write, no handshake back
//
// A sample beat passes the input stage, then the result register; while result_ready is high,
// one beat can be taken on every cycle, as the two registers form a two-deep pipeline.
// All arithmetic for a tick sits between those two registers, and the postscaler count and
// the last valve position are updated on the same edge that loads the result register.
// When result_ready is low the result register holds, the input stage still takes one more
// beat, and sample_ready then falls until the result is taken.
// After arst_n both stages are empty, the count and position are zero and the configuration
// registers hold their documented defaults.
module mixer_valve_temperature_trim_unit #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  mvtt_pkg::sample_t                   sample,

	output logic                                result_valid,
	input  logic                                result_ready,
	output mvtt_pkg::result_t                   result,

	input  logic                                cfg_write,
	input  logic [mvtt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mvtt_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Configuration registers.
	mvtt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint        <= mvtt_pkg::SETPOINT_RST;
			cfg_q.near_band       <= mvtt_pkg::NEAR_BAND_RST;
			cfg_q.undershoot_band <= mvtt_pkg::UNDERSHOOT_BAND_RST;
			cfg_q.overshoot_band  <= mvtt_pkg::OVERSHOOT_BAND_RST;
			cfg_q.trim_gain       <= mvtt_pkg::TRIM_GAIN_RST;
			cfg_q.postscale_limit <= mvtt_pkg::POSTSCALE_LIMIT_RST;
		end else if (cfg_write) begin
			// Writes to indexes beyond the register list fall through and are dropped.
			unique case (mvtt_pkg::reg_index_t'(cfg_index))
				mvtt_pkg::REG_SETPOINT:        cfg_q.setpoint        <= cfg_data[7:0];
				mvtt_pkg::REG_NEAR_BAND:       cfg_q.near_band       <= cfg_data[3:0];
				mvtt_pkg::REG_UNDERSHOOT_BAND: cfg_q.undershoot_band <= cfg_data[3:0];
				mvtt_pkg::REG_OVERSHOOT_BAND:  cfg_q.overshoot_band  <= cfg_data[3:0];
				mvtt_pkg::REG_TRIM_GAIN:       cfg_q.trim_gain       <= cfg_data[3:0];
				mvtt_pkg::REG_POSTSCALE_LIMIT: cfg_q.postscale_limit <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline control. The input stage moves on whenever the result register is empty
	// or is being emptied on this edge.
	logic              valid_s1;
	mvtt_pkg::sample_t sample_s1;
	logic              advance;

	assign advance      = valid_s1 && (!result_valid || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	// Per-tick errors and window flags.
	logic signed [7:0] source_error;
	logic signed [7:0] return_error;
	logic              source_near;
	logic              source_at;
	logic              return_near;
	logic              return_at;

	mvtt_temp_check u_source_check (
		.temp (sample_s1.source_temp),
		.cfg  (cfg_q),
		.err  (source_error),
		.near (source_near),
		.at   (source_at)
	);

	mvtt_temp_check u_return_check (
		.temp (sample_s1.return_temp),
		.cfg  (cfg_q),
		.err  (return_error),
		.near (return_near),
		.at   (return_at)
	);

	// Candidate valve position, used only on ticks where the postscaler fires.
	logic [7:0] step_position;

	mvtt_position u_position (
		.setpoint     (cfg_q.setpoint),
		.trim_gain    (cfg_q.trim_gain),
		.source_error (source_error),
		.position     (step_position)
	);

	// Postscaler and valve state. The count must already exceed the limit for a step to
	// run; it then restarts at zero. Otherwise it counts up and sticks at its maximum.
	logic [COUNT_WIDTH-1:0] tick_count_q;
	logic [7:0]             last_position_q;
	logic                   fire;
	logic                   changed;
	logic [COUNT_WIDTH-1:0] tick_count_next;
	logic [7:0]             position_next;

	always_comb begin
		fire            = 32'(tick_count_q) > 32'(cfg_q.postscale_limit);
		changed         = fire && (step_position != last_position_q);
		position_next   = changed ? step_position : last_position_q;
		tick_count_next = tick_count_q;
		if (fire) begin
			tick_count_next = '0;
		end else if (!(&tick_count_q)) begin
			tick_count_next = tick_count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q    <= '0;
			last_position_q <= '0;
		end else if (advance) begin
			tick_count_q    <= tick_count_next;
			last_position_q <= position_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.step_ran         <= fire;
			result.valve_position   <= position_next;
			result.position_changed <= changed;
			result.source_error     <= source_error;
			result.return_error     <= return_error;
			result.source_near      <= source_near;
			result.source_at        <= source_at;
			result.return_near      <= return_near;
			result.return_at        <= return_at;
		end
	end

endmodule

// File: hdl/mvtt_temp_check.sv
// Error and window flags for one temperature against the setpoint.
// Pure combinational logic; depends on mvtt_pkg for the configuration record.
module mvtt_temp_check (
	input  logic signed [11:0] temp,
	input  mvtt_pkg::cfg_t     cfg,
	output logic signed [7:0]  err,
	output logic               near,
	output logic               at
);

	logic signed [14:0] temp_x;
	logic signed [14:0] sp_x;
	logic signed [14:0] diff;
	logic signed [14:0] deg;
	logic signed [14:0] near_lo;
	logic signed [14:0] near_hi;
	logic signed [14:0] at_lo;
	logic signed [14:0] at_hi;

	always_comb begin
		temp_x = 15'(temp);
		sp_x   = signed'({3'b000, cfg.setpoint, 4'b0000});
		diff   = temp_x - sp_x;

		// Whole degrees, truncated toward zero: an arithmetic shift floors,
		// so a negative value with a fraction left over moves up by one.
		deg = diff >>> mvtt_pkg::FRAC_SHIFT;
		if (diff[14] && (diff[3:0] != 4'b0000)) begin
			deg = deg + 15'sd1;
		end

		if (deg > 15'sd127) begin
			err = 8'sd127;
		end else if (deg < -15'sd128) begin
			err = -8'sd128;
		end else begin
			err = deg[7:0];
		end

		// Window bounds in sixteenths, both ends inclusive.
		near_lo = sp_x - signed'({7'b0000000, cfg.near_band, 4'b0000});
		near_hi = sp_x + signed'({7'b0000000, cfg.near_band, 4'b0000});
		at_lo   = sp_x - signed'({7'b0000000, cfg.undershoot_band, 4'b0000});
		at_hi   = sp_x + signed'({7'b0000000, cfg.overshoot_band, 4'b0000});

		near = (temp_x >= near_lo) && (temp_x <= near_hi);
		at   = (temp_x >= at_lo) && (temp_x <= at_hi);
	end

endmodule

// File: hdl/mvtt_position.sv
// Valve position for one control step: clamped feedforward plus saturated trim.
// Pure combinational logic; depends on mvtt_pkg for constants.
module mvtt_position (
	input  logic [7:0]        setpoint,
	input  logic [3:0]        trim_gain,
	input  logic signed [7:0] source_error,
	output logic [7:0]        position
);

	logic signed [9:0]  sp_delta;
	logic signed [12:0] ff_raw;
	logic [7:0]         ff;
	logic signed [12:0] prod;
	logic signed [7:0]  trim;
	logic signed [9:0]  sum;

	always_comb begin
		sp_delta = signed'({2'b00, setpoint}) - mvtt_pkg::FF_BASE_TEMP;
		ff_raw   = mvtt_pkg::FF_BASE_POS - (13'(sp_delta) <<< mvtt_pkg::FF_SLOPE_SHIFT);

		if (ff_raw < 13'sd0) begin
			ff = mvtt_pkg::POS_MIN;
		end else if (ff_raw > 13'sd255) begin
			ff = mvtt_pkg::POS_MAX;
		end else begin
			ff = ff_raw[7:0];
		end

		prod = 13'(signed'({1'b0, trim_gain})) * 13'(source_error);
		if (prod > 13'sd127) begin
			trim = 8'sd127;
		end else if (prod < -13'sd128) begin
			trim = -8'sd128;
		end else begin
			trim = prod[7:0];
		end

		sum = signed'({2'b00, ff}) + 10'(trim);

		// A feedforward pinned at either end is taken as it stands.
		if ((ff == mvtt_pkg::POS_MIN) || (ff == mvtt_pkg::POS_MAX)) begin
			position = ff;
		end else if (sum < 10'sd0) begin
			position = mvtt_pkg::POS_MIN;
		end else if (sum > signed'({2'b00, mvtt_pkg::POS_TOP_OK})) begin
			position = mvtt_pkg::POS_MAX;
		end else begin
			position = sum[7:0];
		end
	end

endmodule

// File: tb/sv/mixer_valve_temperature_trim_unit_tb.sv
// Self-checking testbench for the mixer valve temperature trim unit.
// Depends on mvtt_pkg and the mixer_valve_temperature_trim_unit RTL; reads no files and
// predicts every result beat with its own model of the postscaler and valve trim.
module mixer_valve_temperature_trim_unit_tb;

	localparam int COUNT_W         = 16;
	localparam int SIXTEENTHS      = 16;
	localparam int FF_POS_AT_BASE  = 200;
	localparam int FF_BASE_DEGREES = 25;
	localparam int FF_SLOPE        = 8;
	localparam int POS_FULL        = 255;
	localparam int POS_TOP         = 254;
	localparam int MAX_GAP         = 10;
	localparam int IDLE_LIMIT      = 2000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int DRAIN_CYCLES    = 8;
	localparam int RANDOM_PHASES   = 10;
	localparam int BEATS_PER_PHASE = 53;
	// An index past the last register; writes to it must leave every register alone.
	localparam logic [mvtt_pkg::CFG_INDEX_W-1:0] UNMAPPED_INDEX = 3'd7;

	logic              clk;
	logic              arst_n;
	logic              sample_valid;
	logic              sample_ready;
	mvtt_pkg::sample_t sample_beat;
	logic              result_valid;
	logic              result_ready;
	mvtt_pkg::result_t result_beat;
	logic              cfg_write;
	logic [mvtt_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [mvtt_pkg::CFG_DATA_W-1:0]  cfg_data;

	// Predictor state: register shadow, postscaler count and last commanded position.
	mvtt_pkg::cfg_t     trim_cfg;
	logic [COUNT_W-1:0] tick_count;
	logic [7:0]         valve_pos;
	mvtt_pkg::result_t  pending_results[$];

	int  mismatches = 0;
	int  idle_cycles = 0;
	// When set, neither side inserts gaps, so the pipeline runs at full rate.
	bit  no_idle = 1'b0;

	mixer_valve_temperature_trim_unit #(
		.COUNT_WIDTH(COUNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample_beat),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result_beat),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int sat_byte(int v);
		if (v > 127) begin
			return 127;
		end
		if (v < -128) begin
			return -128;
		end
		return v;
	endfunction

	// Difference to the setpoint in whole degrees, truncated toward zero, then saturated.
	function automatic int degrees_off(int t16);
		return sat_byte((t16 - int'(trim_cfg.setpoint) * SIXTEENTHS) / SIXTEENTHS);
	endfunction

	// Inclusive window around the setpoint, compared in sixteenths.
	function automatic bit in_band(int t16, int below, int above);
		int lo;
		int hi;
		lo = (int'(trim_cfg.setpoint) - below) * SIXTEENTHS;
		hi = (int'(trim_cfg.setpoint) + above) * SIXTEENTHS;
		return (t16 >= lo) && (t16 <= hi);
	endfunction

	// Works out the result beat of one tick and advances the postscaler and valve state.
	function automatic mvtt_pkg::result_t compute_valve_result(mvtt_pkg::sample_t beat);
		mvtt_pkg::result_t r;
		int src;
		int ret;
		int serr;
		int ff;
		int trim;
		int sum;
		int pos;
		src = int'(beat.source_temp);
		ret = int'(beat.return_temp);
		serr = degrees_off(src);
		r = '0;
		if (tick_count > trim_cfg.postscale_limit) begin
			tick_count = '0;
			r.step_ran = 1'b1;
			ff = FF_POS_AT_BASE - FF_SLOPE * (int'(trim_cfg.setpoint) - FF_BASE_DEGREES);
			if (ff > POS_FULL) begin
				ff = POS_FULL;
			end
			if (ff < 0) begin
				ff = 0;
			end
			trim = sat_byte(int'(trim_cfg.trim_gain) * serr);
			sum = ff + trim;
			pos = ff;
			if (sum > POS_TOP) begin
				pos = POS_FULL;
			end
			if (sum < 0) begin
				pos = 0;
			end
			// A feedforward position pinned at either end skips the trim entirely.
			if (pos != POS_FULL && pos != 0) begin
				pos = sum;
			end
			if (8'(pos) != valve_pos) begin
				valve_pos = 8'(pos);
				r.position_changed = 1'b1;
			end
		end else if (tick_count != '1) begin
			// The count sticks at its maximum instead of wrapping.
			tick_count = tick_count + 1'b1;
		end
		r.valve_position = valve_pos;
		r.source_error   = 8'(serr);
		r.return_error   = 8'(degrees_off(ret));
		r.source_near    = in_band(src, int'(trim_cfg.near_band), int'(trim_cfg.near_band));
		r.source_at      = in_band(src, int'(trim_cfg.undershoot_band),
			int'(trim_cfg.overshoot_band));
		r.return_near    = in_band(ret, int'(trim_cfg.near_band), int'(trim_cfg.near_band));
		r.return_at      = in_band(ret, int'(trim_cfg.undershoot_band),
			int'(trim_cfg.overshoot_band));
		return r;
	endfunction

	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_result(mvtt_pkg::result_t got);
		mvtt_pkg::result_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			$display("%0t: result beat with none expected, expected nothing, actual %h",
				$time, got);
			return;
		end
		want = pending_results.pop_front();
		compare_field("step_ran", int'(want.step_ran), int'(got.step_ran));
		compare_field("valve_position", int'(want.valve_position), int'(got.valve_position));
		compare_field("position_changed", int'(want.position_changed),
			int'(got.position_changed));
		compare_field("source_error", int'(want.source_error), int'(got.source_error));
		compare_field("return_error", int'(want.return_error), int'(got.return_error));
		compare_field("source_near", int'(want.source_near), int'(got.source_near));
		compare_field("source_at", int'(want.source_at), int'(got.source_at));
		compare_field("return_near", int'(want.return_near), int'(got.return_near));
		compare_field("return_at", int'(want.return_at), int'(got.return_at));
	endtask

	// Sends one tick after a random gap and records its expected result once accepted.
	task automatic send_tick(logic signed [11:0] src, logic signed [11:0] ret);
		int gap;
		gap = no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_beat.source_temp <= src;
		sample_beat.return_temp <= ret;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		pending_results.push_back(compute_valve_result('{source_temp: src, return_temp: ret}));
	endtask

	// Holds the sender off until every expected beat is back and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write; only called while the block is idle, so the shadow updates at once.
	task automatic write_reg(logic [mvtt_pkg::CFG_INDEX_W-1:0] index,
		logic [mvtt_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (index)
			mvtt_pkg::REG_SETPOINT:        trim_cfg.setpoint        = data[7:0];
			mvtt_pkg::REG_NEAR_BAND:       trim_cfg.near_band       = data[3:0];
			mvtt_pkg::REG_UNDERSHOOT_BAND: trim_cfg.undershoot_band = data[3:0];
			mvtt_pkg::REG_OVERSHOOT_BAND:  trim_cfg.overshoot_band  = data[3:0];
			mvtt_pkg::REG_TRIM_GAIN:       trim_cfg.trim_gain       = data[3:0];
			mvtt_pkg::REG_POSTSCALE_LIMIT: trim_cfg.postscale_limit = data;
			default: ;
		endcase
	endtask

	// Mostly near the setpoint or on a window bound, with full-range noise mixed in.
	function automatic logic signed [11:0] pick_temp();
		int sp16;
		int t;
		int band;
		logic signed [11:0] raw;
		sp16 = int'(trim_cfg.setpoint) * SIXTEENTHS;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: t = sp16 + int'($urandom_range(0, 640)) - 320;
			6, 7: begin
				raw = 12'($urandom);
				t = int'(raw);
			end
			8: t = int'($urandom_range(0, 2880)) - 880;
			default: begin
				case ($urandom_range(0, 2))
					0: band = -int'(trim_cfg.undershoot_band);
					1: band = int'(trim_cfg.overshoot_band);
					default: band = $urandom_range(0, 1) ? int'(trim_cfg.near_band)
						: -int'(trim_cfg.near_band);
				endcase
				t = sp16 + band * SIXTEENTHS + int'($urandom_range(0, 2)) - 1;
			end
		endcase
		if (t > 2047) begin
			t = 2047;
		end
		if (t < -2048) begin
			t = -2048;
		end
		return 12'(t);
	endfunction

	// Window bounds, error truncation and the temperature extremes, with no steps running.
	task automatic test_windows_and_errors();
		write_reg(mvtt_pkg::REG_SETPOINT, 16'd40);
		write_reg(mvtt_pkg::REG_NEAR_BAND, 16'd4);
		write_reg(mvtt_pkg::REG_UNDERSHOOT_BAND, 16'd3);
		write_reg(mvtt_pkg::REG_OVERSHOOT_BAND, 16'd2);
		// Setpoint 40 degrees: near spans 576..704 and at spans 592..672 sixteenths.
		send_tick(12'sd575, 12'sd591);
		send_tick(12'sd576, 12'sd592);
		send_tick(12'sd704, 12'sd672);
		send_tick(12'sd705, 12'sd673);
		// Fractions of a degree either side of the setpoint truncate toward zero.
		send_tick(12'sd639, 12'sd655);
		send_tick(12'sd623, 12'sd657);
		send_tick(-12'sd2048, 12'sd2047);
		send_tick(12'sd2047, -12'sd2048);
		send_tick(-12'sd880, 12'sd2000);
		send_tick(12'sd0, -12'sd1);
		settle();
	endtask

	// With a limit of zero a step runs on one of every two ticks.
	task automatic two_ticks(logic [7:0] sp, logic [3:0] gain, logic signed [11:0] src);
		settle();
		write_reg(mvtt_pkg::REG_SETPOINT, {8'd0, sp});
		write_reg(mvtt_pkg::REG_TRIM_GAIN, {12'd0, gain});
		send_tick(src, pick_temp());
		send_tick(src, pick_temp());
	endtask

	task automatic test_control_steps();
		write_reg(mvtt_pkg::REG_POSTSCALE_LIMIT, 16'd0);
		write_reg(UNMAPPED_INDEX, 16'hFFFF);
		// Feedforward above the range clamps to full open and the trim is skipped.
		two_ticks(8'd0, 4'd15, 12'sd2047);
		// Feedforward lands exactly on zero: trim skipped despite a large positive error.
		two_ticks(8'd50, 4'd15, 12'sd2047);
		// Feedforward below zero clamps to closed.
		two_ticks(8'd255, 4'd15, -12'sd2048);
		// Trim saturates high and the sum clamps to full open.
		two_ticks(8'd25, 4'd15, 12'sd2047);
		// Trim saturates low and the sum goes negative.
		two_ticks(8'd37, 4'd15, -12'sd2048);
		// Zero gain twice: the second step lands on the same position, so no change flag.
		two_ticks(8'd25, 4'd0, 12'sd0);
		two_ticks(8'd25, 4'd0, 12'sd0);
		settle();
	endtask

	task automatic configure_phase(int phase);
		logic [15:0] limit;
		logic [7:0]  sp;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: limit = 16'($urandom_range(0, 5));
			6, 7: limit = 16'($urandom_range(6, 40));
			8: limit = mvtt_pkg::POSTSCALE_LIMIT_RST;
			default: limit = 16'hFFFF;
		endcase
		sp = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(15, 55));
		if (phase == 1) begin
			// Narrowest windows, and a limit the saturating count can never exceed.
			limit = 16'hFFFF;
			write_reg(mvtt_pkg::REG_NEAR_BAND, 16'd0);
			write_reg(mvtt_pkg::REG_UNDERSHOOT_BAND, 16'd0);
			write_reg(mvtt_pkg::REG_OVERSHOOT_BAND, 16'd0);
		end else if (phase == 2) begin
			limit = 16'd1;
			write_reg(mvtt_pkg::REG_NEAR_BAND, 16'd15);
			write_reg(mvtt_pkg::REG_UNDERSHOOT_BAND, 16'd15);
			write_reg(mvtt_pkg::REG_OVERSHOOT_BAND, 16'd15);
		end else begin
			write_reg(mvtt_pkg::REG_NEAR_BAND, 16'($urandom_range(0, 15)));
			write_reg(mvtt_pkg::REG_UNDERSHOOT_BAND, 16'($urandom_range(0, 15)));
			write_reg(mvtt_pkg::REG_OVERSHOOT_BAND, 16'($urandom_range(0, 15)));
		end
		write_reg(mvtt_pkg::REG_SETPOINT, {8'd0, sp});
		write_reg(mvtt_pkg::REG_TRIM_GAIN, 16'($urandom_range(0, 15)));
		write_reg(mvtt_pkg::REG_POSTSCALE_LIMIT, limit);
		if ($urandom_range(0, 2) == 0) begin
			write_reg(3'(UNMAPPED_INDEX - $urandom_range(0, 1)), 16'($urandom));
		end
		no_idle = ($urandom_range(0, 3) == 0);
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			configure_phase(phase);
			for (int n = 0; n < BEATS_PER_PHASE; n++) begin
				send_tick(pick_temp(), pick_temp());
			end
		end
		no_idle = 1'b0;
		settle();
	endtask

	// Result side: random stalls before each beat, checked against the oldest expectation.
	initial begin : result_drain
		int stall;
		result_ready = 1'b0;
		wait (arst_n);
		forever begin
			stall = no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
			if (stall > 0) begin
				@(negedge clk);
				result_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			check_result(result_beat);
		end
	end

	// Ends the run if no beat moves on either channel for too long.
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin : run
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample_beat  = '0;
		cfg_write    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		trim_cfg     = '{setpoint: mvtt_pkg::SETPOINT_RST,
			near_band: mvtt_pkg::NEAR_BAND_RST,
			undershoot_band: mvtt_pkg::UNDERSHOOT_BAND_RST,
			overshoot_band: mvtt_pkg::OVERSHOOT_BAND_RST,
			trim_gain: mvtt_pkg::TRIM_GAIN_RST,
			postscale_limit: mvtt_pkg::POSTSCALE_LIMIT_RST};
		tick_count   = '0;
		valve_pos    = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		test_windows_and_errors();
		test_control_steps();
		test_random_traffic();
		// Any stray beat after the last expected one shows up as a mismatch here.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: mixer_valve_temperature_trim_unit.f
hdl/mvtt_pkg.sv
hdl/mvtt_temp_check.sv
hdl/mvtt_position.sv
hdl/mixer_valve_temperature_trim_unit.sv
tb/sv/mixer_valve_temperature_trim_unit_tb.sv
